### src/hwre_pkg.sv
// ---------------------------------------------------------------------------
// hwre_pkg: shared types and constants
// Field widths, register indexes and error codes of the resume expander.
// ---------------------------------------------------------------------------
package hwre_pkg;

    localparam int OP_W    = 1;
    localparam int LIDX_W  = 6;
    localparam int LTIM_W  = 24;
    localparam int AMP_W   = 9;
    localparam int POS_W   = 30;
    localparam int REP_W   = 16;
    localparam int REM_W   = 32;
    localparam int ERR_W   = 3;
    localparam int RIDX_W  = 7;
    localparam int CNT_W   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 30;

    localparam logic [OP_W-1:0] OP_LOAD    = 1'b0;
    localparam logic [OP_W-1:0] OP_RESOLVE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SEG_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SEGMENTS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REP_FOREVER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REP_COUNT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REP_START    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PLANNED      = 3'd6;

    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_WAVEFORM = 3'd1;
    localparam logic [ERR_W-1:0] ERR_PLAN     = 3'd2;
    localparam logic [ERR_W-1:0] ERR_POSITION = 3'd3;
    localparam logic [ERR_W-1:0] ERR_DURATION = 3'd4;
    localparam logic [ERR_W-1:0] ERR_SEG_LIM  = 3'd5;

    localparam logic [AMP_W-1:0]  AMP_DEFAULT = 9'h1FF;
    localparam logic [RIDX_W-1:0] RIDX_NONE   = 7'h7F;
    localparam logic [CNT_W-1:0]  OUT_LIMIT   = 7'd64;

    typedef struct packed {
        logic [LTIM_W-1:0]       seg_timing_ms;
        logic signed [AMP_W-1:0] seg_amplitude;
        logic                    last;
        logic [ERR_W-1:0]        error_code;
        logic signed [RIDX_W-1:0] repeat_index;
        logic [REM_W-1:0]        completion_ms;
    } t_out_item;

endpackage

### src/hwre_in_if.sv
// ---------------------------------------------------------------------------
// hwre_in_if: input item channel
// Valid/ready channel carrying load and resolve items.
// ---------------------------------------------------------------------------
interface hwre_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [hwre_pkg::OP_W-1:0]            op;
    logic [hwre_pkg::LIDX_W-1:0]          load_index;
    logic [hwre_pkg::LTIM_W-1:0]          load_timing_ms;
    logic signed [hwre_pkg::AMP_W-1:0]    load_amplitude;
    logic [hwre_pkg::POS_W-1:0]           position_ms;
    logic [hwre_pkg::REP_W-1:0]           completed_repeats;
    logic [hwre_pkg::REM_W-1:0]           remaining_active_ms;

    modport source (output valid, op, load_index, load_timing_ms, load_amplitude,
                    position_ms, completed_repeats, remaining_active_ms,
                    input ready);
    modport sink   (input valid, op, load_index, load_timing_ms, load_amplitude,
                    position_ms, completed_repeats, remaining_active_ms,
                    output ready);
endinterface

### src/hwre_out_if.sv
// ---------------------------------------------------------------------------
// hwre_out_if: result item channel
// Valid/ready channel carrying output segments and error results.
// ---------------------------------------------------------------------------
interface hwre_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [hwre_pkg::LTIM_W-1:0]          seg_timing_ms;
    logic signed [hwre_pkg::AMP_W-1:0]    seg_amplitude;
    logic                                 last;
    logic [hwre_pkg::ERR_W-1:0]           error_code;
    logic signed [hwre_pkg::RIDX_W-1:0]   repeat_index;
    logic [hwre_pkg::REM_W-1:0]           completion_ms;

    modport source (output valid, seg_timing_ms, seg_amplitude, last, error_code,
                    repeat_index, completion_ms, input ready);
    modport sink   (input valid, seg_timing_ms, seg_amplitude, last, error_code,
                    repeat_index, completion_ms, output ready);
endinterface

### src/haptic_waveform_resume_expander_unit.sv
// ---------------------------------------------------------------------------
// haptic_waveform_resume_expander_unit: resume a stored haptic pattern
// Stores segments, validates a resume request and streams the trimmed
// remainder of the pattern plus any repeated tail segments.
// ---------------------------------------------------------------------------
//
//  Channel   Dir   Transfer carries
//  --------  ----  -----------------------------------------------------
//  i_in      in    load (slot, timing, amplitude) or resolve request
//  o_out     out   one output segment or one error result, last flagged
//  i_cfg_*   in    register write (index, data), no handshake
//
//  Resolve: the store is scanned and the request evaluated, then one result
//  per cycle while o_out is not stalled (single read port of the store
//  sets this). An error gives one result, marked last, in place of segments.
//  Reset: synchronous, clears control and config; the store is not cleared.
//  Stalls: a 2-entry output queue with read credits; o_out back-pressure
//  pauses store reads without losing data. i_in is ready only when idle.
//
module haptic_waveform_resume_expander_unit #(
    parameter int SEG_DEPTH = 64,
    parameter int TIME_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    hwre_in_if.sink                             i_in,
    hwre_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [hwre_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [hwre_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW = (SEG_DEPTH > 1) ? $clog2(SEG_DEPTH) : 1;
    localparam int IW = (AW > 7) ? AW : 7;
    // sum of up to 127 timings; at least 32 bits for time compares
    localparam int SW = (TIME_BITS + 7 > 32) ? TIME_BITS + 7 : 32;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_EVAL1 = 3'd2;
    localparam logic [2:0] S_EVAL2 = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_ERR   = 3'd5;

    // ---------------- configuration registers ----------------
    logic [hwre_pkg::CNT_W-1:0] r_seg_count;
    logic [hwre_pkg::CNT_W-1:0] r_max_seg;
    logic                       r_loop_en;
    logic                       r_forever;
    logic [hwre_pkg::REP_W-1:0] r_rep_count;
    logic [hwre_pkg::POS_W-1:0] r_rep_start;
    logic [hwre_pkg::POS_W-1:0] r_planned;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= 7'd1;
            r_max_seg   <= 7'd64;
            r_loop_en   <= 1'b0;
            r_forever   <= 1'b0;
            r_rep_count <= '0;
            r_rep_start <= '0;
            r_planned   <= 30'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hwre_pkg::REG_SEG_COUNT:    r_seg_count <= i_cfg_data[6:0];
                hwre_pkg::REG_MAX_SEGMENTS: r_max_seg   <= i_cfg_data[6:0];
                hwre_pkg::REG_LOOP_ENABLE:  r_loop_en   <= i_cfg_data[0];
                hwre_pkg::REG_REP_FOREVER:  r_forever   <= i_cfg_data[0];
                hwre_pkg::REG_REP_COUNT:    r_rep_count <= i_cfg_data[15:0];
                hwre_pkg::REG_REP_START:    r_rep_start <= i_cfg_data;
                hwre_pkg::REG_PLANNED:      r_planned   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- segment store ----------------
    logic [TIME_BITS-1:0]         mem_t [SEG_DEPTH];
    logic [hwre_pkg::AMP_W-1:0]   mem_a [SEG_DEPTH];
    logic [AW-1:0]                rd_addr;
    logic [TIME_BITS-1:0]         r_rd_t;
    logic [hwre_pkg::AMP_W-1:0]   r_rd_a;
    logic                         in_xfer;
    logic                         mem_we;

    assign in_xfer = i_in.valid && i_in.ready;
    assign mem_we  = in_xfer && (i_in.op == hwre_pkg::OP_LOAD) &&
                     (int'(i_in.load_index) < SEG_DEPTH);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_t[AW'(i_in.load_index)] <= TIME_BITS'(i_in.load_timing_ms);
            mem_a[AW'(i_in.load_index)] <= i_in.load_amplitude;
        end
        r_rd_t <= mem_t[rd_addr];
        r_rd_a <= mem_a[rd_addr];
    end

    // ---------------- control state ----------------
    logic [2:0]                  r_state;
    logic [IW-1:0]               r_ia;        // issue index
    logic                        r_pv;        // scan data arriving
    logic [IW-1:0]               r_pi;        // index of arriving scan data
    logic [SW-1:0]               r_start;     // running start time / pattern sum
    logic                        r_wbad;
    logic                        r_seg_hit;
    logic [IW-1:0]               r_seg;
    logic [TIME_BITS-1:0]        r_d;         // trimmed first segment
    logic                        r_tail_hit;
    logic [IW-1:0]               r_tail;
    logic [hwre_pkg::POS_W-1:0]  r_pos;
    logic [hwre_pkg::REP_W-1:0]  r_done_rep;
    logic [hwre_pkg::REM_W-1:0]  r_remain;
    logic                        r_e2a, r_e3, r_e4;
    logic [hwre_pkg::CNT_W-1:0]  r_need;
    logic [hwre_pkg::CNT_W-1:0]  r_limit;
    logic [22:0]                 r_prod;      // extra copies * tail length
    logic [hwre_pkg::RIDX_W-1:0] r_rep;
    logic [hwre_pkg::REP_W-1:0]  r_copies;
    logic [hwre_pkg::ERR_W-1:0]  r_err;
    logic                        r_head;
    logic                        r_first;
    logic [SW-1:0]               r_esum;
    logic                        r_fv, r_ff, r_fl;  // emit data arriving

    // output queue
    hwre_pkg::t_out_item         r_fifo [2];
    logic                        r_wp, r_rp;
    logic [1:0]                  r_cnt;
    logic                        push, pop;
    hwre_pkg::t_out_item         push_item;

    logic [IW-1:0]               cnt_ext;
    logic                        chk_issue, emit_issue, emit_room, is_end, is_last;
    logic [SW-1:0]               scan_end;
    logic [TIME_BITS-1:0]        arr_val;
    logic [SW-1:0]               esum_n;
    logic [SW-1:0]               comp_w;
    logic                        pre_bad;
    logic [SW-1:0]               diff;
    logic                        reuse;
    logic [hwre_pkg::REP_W-1:0]  extra;
    logic [hwre_pkg::CNT_W-1:0]  tail_len;
    logic [hwre_pkg::CNT_W-1:0]  need_w;
    logic                        amp_bad;

    assign cnt_ext    = IW'(r_seg_count);
    assign i_in.ready = (r_state == S_IDLE);
    assign pop        = o_out.valid && o_out.ready;
    assign chk_issue  = (r_state == S_CHECK) && (r_ia < cnt_ext);
    // a read may start when the queue will have space on arrival
    assign emit_room  = ({1'b0, r_cnt} + {2'b0, r_fv}) < (3'd2 + {2'b0, pop});
    assign emit_issue = (r_state == S_EMIT) && emit_room;
    assign is_end     = (r_ia == cnt_ext - 1'b1);
    assign is_last    = is_end && (r_head ? (r_copies == '0) : (r_copies == 16'd1));
    assign rd_addr    = AW'(r_ia);

    assign scan_end = r_start + SW'(r_rd_t);
    assign amp_bad  = r_rd_a[8] && (r_rd_a != hwre_pkg::AMP_DEFAULT);
    assign pre_bad  = (r_seg_count == '0) || (int'(r_seg_count) > SEG_DEPTH) ||
                      (r_max_seg == '0);

    assign diff   = (r_start > SW'(r_planned)) ? r_start - SW'(r_planned)
                                               : SW'(r_planned) - r_start;
    assign reuse  = r_forever && (r_pos == '0) && (r_done_rep == '0);
    assign extra  = reuse ? '0 : (r_forever ? 16'd1 : r_rep_count - r_done_rep);
    assign tail_len = 7'(cnt_ext - r_tail);
    assign need_w   = 7'(cnt_ext - r_seg);

    assign arr_val = r_ff ? r_d : r_rd_t;
    assign esum_n  = r_esum + SW'(arr_val);
    assign comp_w  = r_forever ? SW'(r_remain)
                   : ((esum_n < SW'(r_remain)) ? esum_n : SW'(r_remain));

    always_comb begin
        push_item = '0;
        push      = 1'b0;
        if (r_state == S_ERR && r_cnt != 2'd2) begin
            push                    = 1'b1;
            push_item.last          = 1'b1;
            push_item.error_code    = r_err;
            push_item.repeat_index  = hwre_pkg::RIDX_NONE;
        end else if (r_fv) begin
            push                    = 1'b1;
            push_item.seg_timing_ms = 24'(arr_val);
            push_item.seg_amplitude = r_rd_a;
            push_item.last          = r_fl;
            push_item.error_code    = hwre_pkg::ERR_NONE;
            push_item.repeat_index  = r_rep;
            push_item.completion_ms = r_fl ? 32'(comp_w) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
            r_fv    <= 1'b0;
            r_cnt   <= '0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
        end else begin
            r_pv <= chk_issue;
            r_fv <= emit_issue;
            if (push) begin
                r_fifo[r_wp] <= push_item;
                r_wp         <= ~r_wp;
            end
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
            if (r_fv) r_esum <= esum_n;

            case (r_state)
                S_IDLE: begin
                    if (in_xfer && i_in.op == hwre_pkg::OP_RESOLVE) begin
                        r_pos      <= i_in.position_ms;
                        r_done_rep <= i_in.completed_repeats;
                        r_remain   <= i_in.remaining_active_ms;
                        r_ia       <= '0;
                        r_start    <= '0;
                        r_wbad     <= 1'b0;
                        r_seg_hit  <= 1'b0;
                        r_tail_hit <= 1'b0;
                        // clamped position falls in the last segment, 1 ms left
                        r_seg      <= cnt_ext - 1'b1;
                        r_d        <= TIME_BITS'(1);
                        r_tail     <= '0;
                        if (pre_bad) begin
                            r_err   <= hwre_pkg::ERR_WAVEFORM;
                            r_state <= S_ERR;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (chk_issue) r_ia <= r_ia + 1'b1;
                    r_pi <= r_ia;
                    if (r_pv) begin
                        if (r_rd_t == '0 || amp_bad) r_wbad <= 1'b1;
                        if (!r_seg_hit && SW'(r_pos) < scan_end) begin
                            r_seg_hit <= 1'b1;
                            r_seg     <= r_pi;
                            r_d       <= TIME_BITS'(scan_end - SW'(r_pos));
                        end
                        if (!r_tail_hit && r_start == SW'(r_rep_start)) begin
                            r_tail_hit <= 1'b1;
                            r_tail     <= r_pi;
                        end
                        r_start <= scan_end;
                        if (r_pi == cnt_ext - 1'b1) r_state <= S_EVAL1;
                    end
                end
                S_EVAL1: begin
                    r_e2a   <= (r_planned == '0) || (diff > SW'(1)) ||
                               (!r_forever && r_done_rep > r_rep_count);
                    r_e3    <= (r_pos >= r_planned);
                    r_e4    <= (r_remain == '0);
                    r_limit <= (r_max_seg > hwre_pkg::OUT_LIMIT) ? hwre_pkg::OUT_LIMIT
                                                                : r_max_seg;
                    r_need  <= need_w;
                    r_prod  <= 23'(extra) * 23'(tail_len);
                    r_copies <= r_loop_en ? extra : '0;
                    if (!r_loop_en)      r_rep <= hwre_pkg::RIDX_NONE;
                    else if (reuse)      r_rep <= 7'(r_tail);
                    else if (r_forever)  r_rep <= need_w;
                    else                 r_rep <= hwre_pkg::RIDX_NONE;
                    r_state <= S_EVAL2;
                end
                S_EVAL2: begin
                    r_ia    <= r_seg;
                    r_head  <= 1'b1;
                    r_first <= 1'b1;
                    r_esum  <= '0;
                    r_state <= S_ERR;
                    if (r_wbad)                        r_err <= hwre_pkg::ERR_WAVEFORM;
                    else if (r_e2a)                    r_err <= hwre_pkg::ERR_PLAN;
                    else if (r_e3)                     r_err <= hwre_pkg::ERR_POSITION;
                    else if (r_e4)                     r_err <= hwre_pkg::ERR_DURATION;
                    else if (r_need > r_limit)         r_err <= hwre_pkg::ERR_SEG_LIM;
                    else if (r_loop_en && !r_tail_hit) r_err <= hwre_pkg::ERR_PLAN;
                    else if (r_loop_en &&
                             (24'(r_need) + 24'(r_prod)) > 24'(r_limit))
                                                       r_err <= hwre_pkg::ERR_SEG_LIM;
                    else                               r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (emit_issue) begin
                        r_ff    <= r_first;
                        r_fl    <= is_last;
                        r_first <= 1'b0;
                        if (is_last) begin
                            r_state <= S_IDLE;
                        end else if (is_end) begin
                            r_ia <= r_tail;
                            if (r_head) r_head <= 1'b0;
                            else        r_copies <= r_copies - 1'b1;
                        end else begin
                            r_ia <= r_ia + 1'b1;
                        end
                    end
                end
                S_ERR: begin
                    if (push) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid         = (r_cnt != 2'd0);
    assign o_out.seg_timing_ms = r_fifo[r_rp].seg_timing_ms;
    assign o_out.seg_amplitude = r_fifo[r_rp].seg_amplitude;
    assign o_out.last          = r_fifo[r_rp].last;
    assign o_out.error_code    = r_fifo[r_rp].error_code;
    assign o_out.repeat_index  = r_fifo[r_rp].repeat_index;
    assign o_out.completion_ms = r_fifo[r_rp].completion_ms;

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("output queue count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_cnt != 2'd2 || pop)) else $error("output queue overflow");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && push_item.error_code != hwre_pkg::ERR_NONE) |-> push_item.last)
        else $error("error result not marked last");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pv) else $error("scan data outside scan");
`endif

endmodule
